// File: rtl/wtcqa_pkg.sv
// Package for the weighted two-class queue arbiter.
// Holds the request and result types, operation and status codes, and reset constants.
// No dependencies.
package wtcqa_pkg;

    localparam int ID_W                = 16;
    localparam int WEIGHT_W            = 4;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd3;
    localparam logic [WEIGHT_W-1:0] ROW_MAX      = 4'd15;

    typedef enum logic [1:0] {
        OP_ENQ_NORMAL   = 2'd0,
        OP_ENQ_PRIORITY = 2'd1,
        OP_SERVE        = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t              operation;
        logic [ID_W-1:0]  client_id;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]  served_id;
        logic             served_priority;
        status_t          status;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

// File: rtl/wtcqa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module wtcqa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/wtcqa_queue.sv
// One FIFO class queue: head, tail and occupancy around a registered-read RAM.
// Depends on wtcqa_pkg and wtcqa_ram.
module wtcqa_queue #(
    parameter int DEPTH = wtcqa_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wtcqa_pkg::queue_ctl_t      ctl,
    input  logic [wtcqa_pkg::ID_W-1:0] wdata,
    output wtcqa_pkg::queue_stat_t     stat,
    output logic [wtcqa_pkg::ID_W-1:0] rdata
);

    import wtcqa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.push)
        begin
            tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

    wtcqa_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (tail_reg),
        .wdata (wdata),
        .re    (ctl.pop),
        .raddr (head_reg),
        .rdata (rdata)
    );

endmodule

// File: rtl/weighted_two_class_queue_arbiter.sv
// A request is registered in stage s1, then its result is registered and flagged by done.
// Throughput: one request per cycle; busy is never raised and results cannot be stalled.
// The queue pointers and the ratio counter are updated from their own registered values.
// Reset clears both queues, the ratio counter and sets the weight to 3; stored IDs are kept.
// Depends on wtcqa_pkg and wtcqa_queue.
module weighted_two_class_queue_arbiter #(
    parameter int QUEUE_DEPTH = wtcqa_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  wtcqa_pkg::cmd_t                cmd,
    output logic                           done,
    output wtcqa_pkg::result_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wtcqa_pkg::WEIGHT_W-1:0] cfg_data
);

    import wtcqa_pkg::*;

    logic                accept;
    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [WEIGHT_W-1:0] row_reg, row_next;

    queue_ctl_t          pri_ctl, nor_ctl;
    queue_stat_t         pri_stat, nor_stat;
    logic [ID_W-1:0]     pri_rdata, nor_rdata;

    logic                done_reg;
    status_t             status_reg, status_next;
    logic                pri_sel_reg, pri_sel_next;
    logic                pop_reg, pop_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            weight_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
        end
    end

    // A waiting priority client wins while the row counter is below the weight or no normal client waits.
    always_comb
    begin
        pri_ctl      = '0;
        nor_ctl      = '0;
        row_next     = row_reg;
        status_next  = ST_OK;
        pri_sel_next = 1'b0;
        pop_next     = 1'b0;
        if (s1_valid_reg)
        begin
            case (s1_cmd_reg.operation)
                OP_ENQ_NORMAL:
                begin
                    if (nor_stat.full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        nor_ctl.push = 1'b1;
                    end
                end
                OP_ENQ_PRIORITY:
                begin
                    if (pri_stat.full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        pri_ctl.push = 1'b1;
                    end
                end
                OP_SERVE:
                begin
                    if (!pri_stat.empty && (nor_stat.empty || row_reg < weight_reg))
                    begin
                        pri_ctl.pop  = 1'b1;
                        pri_sel_next = 1'b1;
                        pop_next     = 1'b1;
                        if (row_reg != ROW_MAX)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else if (!nor_stat.empty)
                    begin
                        nor_ctl.pop = 1'b1;
                        pop_next    = 1'b1;
                        row_next    = '0;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            pri_sel_reg <= 1'b0;
            pop_reg     <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            done_reg    <= s1_valid_reg;
            status_reg  <= status_next;
            pri_sel_reg <= pri_sel_next;
            pop_reg     <= pop_next;
        end
    end

    wtcqa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_pri_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pri_ctl),
        .wdata (s1_cmd_reg.client_id),
        .stat  (pri_stat),
        .rdata (pri_rdata)
    );

    wtcqa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_nor_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (nor_ctl),
        .wdata (s1_cmd_reg.client_id),
        .stat  (nor_stat),
        .rdata (nor_rdata)
    );

    // The RAM read registers hold the popped ID during the result cycle.
    assign done                   = done_reg;
    assign result.served_id       = !pop_reg ? '0 : (pri_sel_reg ? pri_rdata : nor_rdata);
    assign result.served_priority = pri_sel_reg;
    assign result.status          = status_reg;

endmodule

// File: rtl/wtcqa_checker.sv
// Port-level checks for the weighted two-class queue arbiter, bound to the top level.
// Depends on wtcqa_pkg and weighted_two_class_queue_arbiter.
module wtcqa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input wtcqa_pkg::result_t             result
);

    import wtcqa_pkg::*;

    // Every accepted request produces its result strobe on done.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted request did not complete after two cycles");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without a matching request");

    // A result with an error status carries no client.
    a_no_client_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.served_id == '0 && !result.served_priority))
        else $error("client reported together with an error status");

    // Result ports rest at zero between results.
    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (result == '0))
        else $error("result ports not zero outside a result cycle");

endmodule

bind weighted_two_class_queue_arbiter wtcqa_checker u_checker (.*);

// File: dv/weighted_two_class_queue_arbiter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the weighted two-class queue arbiter: random and directed
// enqueue/serve requests, checked against a behavioral predictor of both client lines.
// Depends on wtcqa_pkg and the weighted_two_class_queue_arbiter RTL.
module weighted_two_class_queue_arbiter_tb;

    import wtcqa_pkg::*;

    localparam int          LINE_DEPTH  = 16;
    localparam int          STALL_LIMIT = 2000;
    localparam int          SETTLE      = 4;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    cmd_t                cmd = '0;
    logic                done;
    result_t             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WEIGHT_W-1:0] cfg_data = '0;

    // Stimulus and scoreboard state.
    cmd_t                queued_requests[$];
    result_t             awaited_results[$];
    int unsigned         sender_idle_pct = 0;
    int unsigned         mismatch_count = 0;
    int unsigned         quiet_cycles = 0;

    // Predictor state.
    logic [ID_W-1:0]     priority_line[$];
    logic [ID_W-1:0]     normal_line[$];
    logic [WEIGHT_W-1:0] ratio_count = '0;
    logic [WEIGHT_W-1:0] weight_now = WEIGHT_RESET;

    weighted_two_class_queue_arbiter #(
        .QUEUE_DEPTH(LINE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic result_t arbitrate_request(cmd_t c);
        result_t r;
        r = '0;
        r.status = ST_OK;
        case (c.operation)
            OP_ENQ_NORMAL:
            begin
                if (normal_line.size() >= LINE_DEPTH)
                    r.status = ST_FULL;
                else
                    normal_line.push_back(c.client_id);
            end
            OP_ENQ_PRIORITY:
            begin
                if (priority_line.size() >= LINE_DEPTH)
                    r.status = ST_FULL;
                else
                    priority_line.push_back(c.client_id);
            end
            OP_SERVE:
            begin
                if (priority_line.size() > 0 &&
                    (normal_line.size() == 0 || ratio_count < weight_now))
                begin
                    r.served_id = priority_line.pop_front();
                    r.served_priority = 1'b1;
                    if (ratio_count < ROW_MAX)
                        ratio_count++;
                end
                else if (normal_line.size() > 0)
                begin
                    r.served_id = normal_line.pop_front();
                    ratio_count = '0;
                end
                else
                begin
                    r.status = ST_EMPTY;
                end
            end
            default:
            begin
                // The unused operation code leaves everything untouched.
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver: a new request is offered at the falling edge, held while busy.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && busy))
        begin
            if (queued_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                cmd   <= queued_requests[0];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                weight_now = cfg_data;
            if (start && !busy)
            begin
                awaited_results.push_back(arbitrate_request(cmd));
                void'(queued_requests.pop_front());
            end
            if (done)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no request waiting", result, 0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.served_id !== want.served_id)
                        report_mismatch("served_id", result.served_id, want.served_id);
                    if (result.served_priority !== want.served_priority)
                        report_mismatch("served_priority", result.served_priority,
                                        want.served_priority);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                end
            end
        end
    end

    // Watchdog on cycles in which no handshake of any kind completes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("weighted_two_class_queue_arbiter: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_request(input logic [1:0] op, input logic [ID_W-1:0] id);
        cmd_t c;
        c.operation = op_t'(op);
        c.client_id = id;
        queued_requests.push_back(c);
    endtask

    task automatic add_serves(input int n);
        for (int i = 0; i < n; i++)
            add_request(OP_SERVE, ID_W'($urandom));
    endtask

    task automatic add_enqueues(input logic [1:0] op, input int n);
        for (int i = 0; i < n; i++)
            add_request(op, ID_W'($urandom_range(0, 65535)));
    endtask

    // Builds a phase out of request sequences: fill bursts that overflow a line,
    // random mixes, drains past empty, and long priority runs that saturate the
    // ratio counter.
    task automatic add_random_phase(input int count);
        int start_size;
        int kind;
        int n;
        int pick;
        start_size = queued_requests.size();
        while (queued_requests.size() - start_size < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                add_enqueues($urandom_range(0, 1) ? OP_ENQ_PRIORITY : OP_ENQ_NORMAL,
                             $urandom_range(4, 20));
                add_serves($urandom_range(4, 24));
            end
            else if (kind <= 6)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                        add_enqueues(OP_ENQ_NORMAL, 1);
                    else if (pick < 60)
                        add_enqueues(OP_ENQ_PRIORITY, 1);
                    else if (pick < 97)
                        add_serves(1);
                    else
                        add_enqueues(OP_UNUSED, 1);
                end
            end
            else if (kind == 7)
            begin
                n = $urandom_range(8, 16);
                add_enqueues(OP_ENQ_NORMAL, $urandom_range(1, 4));
                add_enqueues(OP_ENQ_PRIORITY, n);
                add_serves(n + $urandom_range(0, 6));
            end
            else if (kind == 8)
            begin
                // Empty both lines, then serve a long priority run with no normal client.
                add_serves(2 * LINE_DEPTH + 2);
                for (int r = 0; r < 2; r++)
                begin
                    add_enqueues(OP_ENQ_PRIORITY, LINE_DEPTH);
                    add_serves(LINE_DEPTH);
                end
                add_enqueues(OP_ENQ_NORMAL, 1);
                add_enqueues(OP_ENQ_PRIORITY, 2);
                add_serves(3);
            end
            else
            begin
                add_serves($urandom_range(10, 34));
            end
        end
    endtask

    task automatic wait_until_idle();
        while (queued_requests.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [WEIGHT_W-1:0] weight_plan[9];
        weight_plan = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd15, 4'd1, 4'd7, 4'd0, 4'd15};
        weight_plan[6] = WEIGHT_W'($urandom_range(1, 15));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset weight of three.
        sender_idle_pct = 35;
        add_serves(1);
        add_request(OP_UNUSED, 16'hFFFF);
        add_request(OP_ENQ_NORMAL, 16'h0000);
        add_request(OP_ENQ_NORMAL, 16'hFFFF);
        add_request(OP_ENQ_PRIORITY, 16'hFFFF);
        add_request(OP_ENQ_PRIORITY, 16'h0000);
        add_request(OP_ENQ_PRIORITY, 16'hA5A5);
        add_request(OP_ENQ_PRIORITY, 16'h5A5A);
        add_request(OP_ENQ_PRIORITY, 16'h1234);
        add_serves(8);
        add_request(OP_ENQ_NORMAL, 16'h8001);
        add_serves(2);
        wait_until_idle();

        // Each phase overshoots its target by about 25 requests on average.
        for (int p = 0; p < 9; p++)
        begin
            write_weight(weight_plan[p]);
            if (p < 3)
                sender_idle_pct = 35;
            else if (p < 6)
                sender_idle_pct = 65;
            else
                sender_idle_pct = 0;
            add_random_phase(125);
            wait_until_idle();
        end

        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);
        if (mismatch_count == 0)
            $display("weighted_two_class_queue_arbiter: match");
        else
            $display("weighted_two_class_queue_arbiter: mismatch");
        $finish;
    end

endmodule
